>>> design/brb_pkg.sv
// shared constants, types and helpers of the byte ring buffer
package brb_pkg;

	// buffer geometry: one spare slot tells full from empty
	localparam int CAPACITY = 8192;
	localparam int SLOTS    = CAPACITY + 1;
	localparam int PTR_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// transaction field widths
	localparam int OP_W   = 2;
	localparam int DATA_W = 8;
	localparam int LEN_W  = 14;
	localparam int OFF_W  = 13;
	localparam int STS_W  = 2;

	localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
	localparam logic [PTR_W:0]   SLOTS_C = (PTR_W + 1)'(SLOTS);

	// operation codes
	localparam logic [OP_W-1:0] OP_APPEND   = 2'd0;
	localparam logic [OP_W-1:0] OP_PEEK     = 2'd1;
	localparam logic [OP_W-1:0] OP_RETRIEVE = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STATUS_DROPPED  = 2'd1;
	localparam logic [STS_W-1:0] STATUS_PEEK_ERR = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
		logic load_byte;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_read;
	} sts_t;

	// pointer advance with wrap at the slot count
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
		input logic [PTR_W-1:0] amount);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, amount};
		if (sum >= SLOTS_C) begin
			sum = sum - SLOTS_C;
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

>>> design/brb_ctrl.sv
// sequencing controller of the byte ring buffer
module brb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output brb_pkg::cmd_t cmd,
	input  brb_pkg::sts_t sts
);
	import brb_pkg::*;

	state_t state_q;
	state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_n     = sts.need_read ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				cmd.load_byte = 1'b1;
				state_n       = ST_DONE;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// one transaction in flight at a time
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result is pending");

	// an accepted transaction is executed in the next cycle
	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.execute)
		else $error("accepted transaction not executed");

	// byte load only right after an execute that needed a read
	a_load_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_byte |-> ($past(cmd.execute) && $past(sts.need_read)))
		else $error("byte load without a preceding peek read");

endmodule

>>> design/brb_datapath.sv
// pointers, byte store and result registers of the byte ring buffer
module brb_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brb_pkg::cmd_t                cmd,
	output brb_pkg::sts_t                sts,
	input  logic [brb_pkg::OP_W-1:0]     operation,
	input  logic                         burst_first,
	input  logic [brb_pkg::DATA_W-1:0]   data_byte,
	input  logic [brb_pkg::LEN_W-1:0]    length,
	input  logic [brb_pkg::OFF_W-1:0]    offset,
	output logic [brb_pkg::DATA_W-1:0]   read_byte,
	output logic [brb_pkg::STS_W-1:0]    status,
	output logic [brb_pkg::CNT_W-1:0]    readable_count,
	output logic [brb_pkg::CNT_W-1:0]    writable_count,
	output logic                         is_empty
);
	import brb_pkg::*;

	// captured transaction
	logic [OP_W-1:0]   op_q;
	logic              first_q;
	logic [DATA_W-1:0] data_q;
	logic [LEN_W-1:0]  len_q;
	logic [OFF_W-1:0]  off_q;

	// buffer state
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;

	// byte store and its registered read port
	logic [DATA_W-1:0] mem [SLOTS];
	logic [DATA_W-1:0] rd_data_q;

	// result registers
	logic [DATA_W-1:0] byte_q;
	logic [STS_W-1:0]  status_q;
	logic [CNT_W-1:0]  readable_q;
	logic [CNT_W-1:0]  writable_q;
	logic              empty_q;

	// execute-cycle next values
	logic [PTR_W-1:0] rp_n;
	logic [PTR_W-1:0] wp_n;
	logic [CNT_W-1:0] count_n;
	logic             drop_n;
	logic [STS_W-1:0] status_n;
	logic             do_write;
	logic             peek_ok;
	logic [CNT_W-1:0] free_cnt;
	logic [PTR_W-1:0] peek_addr;
	logic [PTR_W-1:0] wp_inc;
	logic [PTR_W-1:0] rp_adv;

	// capture transaction fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			first_q <= burst_first;
			data_q  <= data_byte;
			len_q   <= length;
			off_q   <= offset;
		end
	end

	// operation decode and pointer arithmetic
	always_comb begin
		free_cnt  = CAP_C - count_q;
		wp_inc    = wrap_add(wp_q, PTR_W'(1));
		rp_adv    = wrap_add(rp_q, PTR_W'(len_q));
		peek_addr = wrap_add(rp_q, PTR_W'(off_q));
		peek_ok   = (CNT_W'(len_q) <= count_q) && (len_q <= LEN_W'(CAPACITY))
			&& (LEN_W'(off_q) < len_q);
		rp_n      = rp_q;
		wp_n      = wp_q;
		count_n   = count_q;
		drop_n    = drop_q;
		status_n  = STATUS_OK;
		do_write  = 1'b0;
		if (op_q == OP_APPEND) begin
			if (first_q && (len_q > LEN_W'(free_cnt))) begin
				drop_n   = 1'b1;
				status_n = STATUS_DROPPED;
			end else if (!first_q && drop_q) begin
				status_n = STATUS_DROPPED;
			end else begin
				if (first_q) begin
					drop_n = 1'b0;
				end
				if (count_q == CAP_C) begin
					status_n = STATUS_DROPPED;
				end else begin
					do_write = 1'b1;
					wp_n     = wp_inc;
					count_n  = count_q + CNT_W'(1);
				end
			end
		end else if (op_q == OP_PEEK) begin
			if (!peek_ok) begin
				status_n = STATUS_PEEK_ERR;
			end
		end else if (op_q == OP_RETRIEVE) begin
			if (len_q > LEN_W'(count_q)) begin
				rp_n    = wp_q;
				count_n = '0;
			end else begin
				rp_n    = rp_adv;
				count_n = count_q - CNT_W'(len_q);
			end
		end
		sts.need_read = (op_q == OP_PEEK) && peek_ok;
	end

	// pointer, count and burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.execute) begin
			rp_q    <= rp_n;
			wp_q    <= wp_n;
			count_q <= count_n;
			drop_q  <= drop_n;
		end
	end

	// byte store write and peek read
	always_ff @(posedge clk) begin
		if (cmd.execute && do_write) begin
			mem[wp_q] <= data_q;
		end
		if (cmd.execute && sts.need_read) begin
			rd_data_q <= mem[peek_addr];
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			byte_q     <= '0;
			status_q   <= status_n;
			readable_q <= count_n;
			writable_q <= CAP_C - count_n;
			empty_q    <= (rp_n == wp_n);
		end else if (cmd.load_byte) begin
			byte_q <= rd_data_q;
		end
	end

	assign read_byte      = byte_q;
	assign status         = status_q;
	assign readable_count = readable_q;
	assign writable_count = writable_q;
	assign is_empty       = empty_q;

	// fill count never passes capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("fill count above capacity");

	// empty count and equal pointers go together
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (rp_q == wp_q))
		else $error("fill count and pointers disagree");

	// a peek that read the store reports ok
	a_peek_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_byte |=> (status_q == STATUS_OK))
		else $error("peek byte loaded with error status");

endmodule

>>> design/byte_ring_buffer_core.sv
// byte ring buffer: 8192-byte circular fifo with append, peek and retrieve
// results come from registers; the controller steps through capture, execute, an optional
// registered byte store read for a peek that reads the store, and result hold
// a new transaction is taken only in idle, after the previous result has been taken
// reset: arst_n clears pointers, fill count and burst drop flag; store contents undefined
module byte_ring_buffer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [brb_pkg::OP_W-1:0]     operation,
	input  logic                         burst_first,
	input  logic [brb_pkg::DATA_W-1:0]   data_byte,
	input  logic [brb_pkg::LEN_W-1:0]    length,
	input  logic [brb_pkg::OFF_W-1:0]    offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [brb_pkg::DATA_W-1:0]   read_byte,
	output logic [brb_pkg::STS_W-1:0]    status,
	output logic [brb_pkg::CNT_W-1:0]    readable_count,
	output logic [brb_pkg::CNT_W-1:0]    writable_count,
	output logic                         is_empty
);
	import brb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// storage and arithmetic
	brb_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.burst_first    (burst_first),
		.data_byte      (data_byte),
		.length         (length),
		.offset         (offset),
		.read_byte      (read_byte),
		.status         (status),
		.readable_count (readable_count),
		.writable_count (writable_count),
		.is_empty       (is_empty)
	);

endmodule

>>> sim/byte_ring_buffer_core_test.sv
// self-checking testbench for the byte ring buffer core
module byte_ring_buffer_core_test;
	import brb_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1420;
	localparam longint LIMIT_CYCLES = 4000000;

	// one result transaction as seen on the output side
	typedef struct {
		logic [DATA_W-1:0] read_byte;
		logic [STS_W-1:0]  status;
		logic [CNT_W-1:0]  readable;
		logic [CNT_W-1:0]  writable;
		logic              is_empty;
	} fill_result_t;

	// shadow ring buffer plus the queue of results still owed by the block
	class ring_scoreboard;
		logic [DATA_W-1:0] byte_mem [SLOTS];
		int unsigned rd_ptr;
		int unsigned wr_ptr;
		bit drop_active;
		fill_result_t pending_results[$];
		int errors;

		function new();
			rd_ptr = 0;
			wr_ptr = 0;
			drop_active = 1'b0;
			errors = 0;
		endfunction

		function int unsigned bytes_held();
			if (wr_ptr >= rd_ptr) begin
				return wr_ptr - rd_ptr;
			end
			return SLOTS - rd_ptr + wr_ptr;
		endfunction

		function int unsigned bytes_free();
			return CAPACITY - bytes_held();
		endfunction

		function int unsigned ring_advance(int unsigned base, int unsigned amount);
			int unsigned sum;
			sum = base + amount;
			return (sum >= SLOTS) ? sum - SLOTS : sum;
		endfunction

		// store one byte unless the buffer already holds its full capacity
		function logic [STS_W-1:0] push_byte(logic [DATA_W-1:0] value);
			if (bytes_free() == 0) begin
				return STATUS_DROPPED;
			end
			byte_mem[wr_ptr] = value;
			wr_ptr = ring_advance(wr_ptr, 1);
			return STATUS_OK;
		endfunction

		// apply an accepted input transaction and queue the result it owes
		function void note_transaction(logic [OP_W-1:0] op, logic first,
			logic [DATA_W-1:0] data, logic [LEN_W-1:0] len, logic [OFF_W-1:0] off);
			fill_result_t res;
			int unsigned held;
			res.read_byte = '0;
			res.status = STATUS_OK;
			case (op)
				OP_APPEND: begin
					if (first) begin
						if (len > bytes_free()) begin
							drop_active = 1'b1;
							res.status = STATUS_DROPPED;
						end else begin
							drop_active = 1'b0;
							res.status = push_byte(data);
						end
					end else if (drop_active) begin
						res.status = STATUS_DROPPED;
					end else begin
						res.status = push_byte(data);
					end
				end
				OP_PEEK: begin
					if (len > bytes_held() || off >= len) begin
						res.status = STATUS_PEEK_ERR;
					end else begin
						res.read_byte = byte_mem[ring_advance(rd_ptr, off)];
					end
				end
				OP_RETRIEVE: begin
					if (len > bytes_held()) begin
						rd_ptr = wr_ptr;
					end else begin
						rd_ptr = ring_advance(rd_ptr, len);
					end
				end
				default: ;
			endcase
			held = bytes_held();
			res.readable = CNT_W'(held);
			res.writable = CNT_W'(CAPACITY - held);
			res.is_empty = (rd_ptr == wr_ptr);
			pending_results.push_back(res);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		// compare one result transaction with the oldest owed result
		task check_result(fill_result_t got);
			fill_result_t want;
			if (pending_results.size() == 0) begin
				report("result with no transaction pending");
				return;
			end
			want = pending_results.pop_front();
			if (got.read_byte !== want.read_byte) begin
				report($sformatf("read_byte got %0h want %0h", got.read_byte, want.read_byte));
			end
			if (got.status !== want.status) begin
				report($sformatf("status got %0d want %0d", got.status, want.status));
			end
			if (got.readable !== want.readable) begin
				report($sformatf("readable_count got %0d want %0d", got.readable,
					want.readable));
			end
			if (got.writable !== want.writable) begin
				report($sformatf("writable_count got %0d want %0d", got.writable,
					want.writable));
			end
			if (got.is_empty !== want.is_empty) begin
				report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic                burst_first;
	logic [DATA_W-1:0]   data_byte;
	logic [LEN_W-1:0]    length;
	logic [OFF_W-1:0]    offset;
	logic                out_valid;
	logic                out_ready;
	logic [DATA_W-1:0]   read_byte;
	logic [STS_W-1:0]    status;
	logic [CNT_W-1:0]    readable_count;
	logic [CNT_W-1:0]    writable_count;
	logic                is_empty;

	ring_scoreboard sb = new();

	int fed_items = 0;
	int sender_steady = 0;
	bit hold_request = 1'b0;

	byte_ring_buffer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.burst_first    (burst_first),
		.data_byte      (data_byte),
		.length         (length),
		.offset         (offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_byte      (read_byte),
		.status         (status),
		.readable_count (readable_count),
		.writable_count (writable_count),
		.is_empty       (is_empty)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic int sender_gap();
		if (sender_steady > 0) begin
			sender_steady--;
			return 0;
		end
		return gap_cycles();
	endfunction

	// offer one input transaction at a falling edge and hold it until taken
	task automatic send(input logic [OP_W-1:0] op, input logic first,
		input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len,
		input logic [OFF_W-1:0] off);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation <= op;
		burst_first <= first;
		data_byte <= data;
		length <= len;
		offset <= off;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		fed_items++;
	endtask

	// monitor both channels at the rising edge
	always @(posedge clk) begin : monitor_blk
		fill_result_t res;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				res.read_byte = read_byte;
				res.status = status;
				res.readable = readable_count;
				res.writable = writable_count;
				res.is_empty = is_empty;
				sb.check_result(res);
			end
			if (in_valid && in_ready) begin
				sb.note_transaction(operation, burst_first, data_byte, length, offset);
			end
		end
	end

	// result side: random stalls, calm stretches and one long hold-off
	initial begin : receiver_blk
		int stall_left;
		int steady_left;
		int r;
		stall_left = 0;
		steady_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (steady_left > 0) begin
				out_ready <= 1'b1;
				steady_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					steady_left = $urandom_range(40, 150);
				end
				if (r < 75) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall_left = gap_cycles();
				end
			end
		end
	end

	// run time limit
	initial begin
		#(LIMIT_CYCLES * 10);
		$display("** byte_ring_buffer_core: FAILED **");
		$finish;
	end

	// stimulus
	initial begin : stimulus_blk
		int held;
		int room;
		int span;
		int n;
		int k;
		int announced;
		int pick;
		int r;
		int target;
		bit bad;

		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_APPEND;
		burst_first = 1'b0;
		data_byte = '0;
		length = '0;
		offset = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// empty buffer: peeks out of span, clamped retrieve, unused code
		send(OP_PEEK, 1'b0, 8'h00, 14'd0, 13'd0);
		send(OP_PEEK, 1'b1, 8'hFF, 14'd1, 13'd0);
		send(OP_RETRIEVE, 1'b0, 8'h00, 14'd5, 13'd0);
		send(OP_UNUSED, 1'b1, 8'($urandom), LEN_W'($urandom), OFF_W'($urandom));

		// zero-length burst with room stores its byte
		send(OP_APPEND, 1'b1, 8'h00, 14'd0, 13'd0);
		// oversized burst is dropped byte by byte
		send(OP_APPEND, 1'b1, 8'hFF, 14'h3FFF, 13'h1FFF);
		send(OP_APPEND, 1'b0, 8'hAA, 14'd0, 13'd0);
		// a fitting first byte clears the drop
		send(OP_APPEND, 1'b1, 8'hFF, 14'd3, 13'd0);
		send(OP_APPEND, 1'b0, 8'h80, 14'd0, 13'd0);
		send(OP_APPEND, 1'b0, 8'h01, 14'd0, 13'd0);
		for (int i = 0; i < 4; i++) begin
			send(OP_PEEK, 1'b0, 8'h00, 14'd4, OFF_W'(i));
		end
		send(OP_PEEK, 1'b0, 8'h00, 14'd4, 13'd4);
		send(OP_PEEK, 1'b0, 8'h00, 14'd5, 13'd0);
		send(OP_PEEK, 1'b0, 8'h00, 14'h3FFF, 13'h1FFF);
		send(OP_RETRIEVE, 1'b0, 8'h00, 14'd0, 13'd0);
		send(OP_RETRIEVE, 1'b0, 8'h00, 14'd2, 13'd0);
		send(OP_PEEK, 1'b0, 8'h00, 14'd2, 13'd1);
		send(OP_RETRIEVE, 1'b1, 8'hFF, 14'h3FFF, 13'h1FFF);

		// random traffic, starting with a long receiver hold-off
		hold_request = 1'b1;
		sender_steady = 60;
		target = fed_items + RANDOM_ITEMS;
		while (fed_items < target) begin
			held = sb.bytes_held();
			room = sb.bytes_free();
			if ($urandom_range(0, 299) == 0) begin
				sender_steady = $urandom_range(50, 150);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// append burst, usually announced correctly
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
				r = $urandom_range(0, 99);
				if (r < 70) begin
					announced = n;
				end else if (r < 80) begin
					announced = $urandom_range(0, n);
				end else if (r < 90) begin
					announced = $urandom_range(room + 1, 16383);
				end else begin
					announced = $urandom_range(0, 16383);
				end
				for (int i = 0; i < n; i++) begin
					send(OP_APPEND, i == 0, 8'($urandom),
						(i == 0) ? LEN_W'(announced) : LEN_W'($urandom), OFF_W'($urandom));
				end
			end else if (pick < 70) begin
				// peeks into a span, a few of them out of range
				if (held > 0) begin
					span = $urandom_range(1, held);
					bad = ($urandom_range(0, 6) == 0);
					k = $urandom_range(1, 4);
					for (int i = 0; i < k; i++) begin
						if (bad && $urandom_range(0, 1) == 1) begin
							send(OP_PEEK, 1'($urandom), 8'($urandom), LEN_W'(span),
								OFF_W'(span + $urandom_range(0, 3)));
						end else if (bad) begin
							send(OP_PEEK, 1'($urandom), 8'($urandom),
								LEN_W'(held + $urandom_range(1, 9)), OFF_W'($urandom_range(0, 3)));
						end else begin
							send(OP_PEEK, 1'($urandom), 8'($urandom), LEN_W'(span),
								OFF_W'($urandom_range(0, span - 1)));
						end
					end
				end else begin
					send(OP_PEEK, 1'($urandom), 8'($urandom), LEN_W'($urandom_range(0, 3)),
						OFF_W'($urandom_range(0, 3)));
				end
			end else if (pick < 85) begin
				// retrieve, sometimes more than held
				r = $urandom_range(0, 99);
				if (r < 70) begin
					announced = $urandom_range(0, held);
				end else if (r < 85) begin
					announced = held + $urandom_range(1, 100);
				end else begin
					announced = $urandom_range(0, 16383);
				end
				send(OP_RETRIEVE, 1'($urandom), 8'($urandom), LEN_W'(announced),
					OFF_W'($urandom));
			end else if (pick < 92) begin
				send(OP_UNUSED, 1'($urandom), 8'($urandom), LEN_W'($urandom), OFF_W'($urandom));
			end else begin
				// unshaped noise on a valid operation
				r = $urandom_range(0, 2);
				case (r)
					0: send(OP_APPEND, 1'($urandom), 8'($urandom), LEN_W'($urandom),
						OFF_W'($urandom));
					1: send(OP_PEEK, 1'($urandom), 8'($urandom), LEN_W'($urandom),
						OFF_W'($urandom));
					default: send(OP_RETRIEVE, 1'($urandom), 8'($urandom), LEN_W'($urandom),
						OFF_W'($urandom));
				endcase
			end
		end
		in_valid <= 1'b0;

		// drain the owed results, then keep watching for stray results before the verdict
		while (sb.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** byte_ring_buffer_core: PASSED **");
		end else begin
			$display("** byte_ring_buffer_core: FAILED **");
		end
		$finish;
	end

endmodule
